// ----- rtl/ltd_pkg.sv -----
// ltd_pkg: shared types and constants for the lexer token automaton
// no dependencies
package ltd_pkg;

   typedef enum logic [2:0] {
      MODE_EMPTY = 3'd0,
      MODE_IDENT = 3'd1,
      MODE_INT   = 3'd2,
      MODE_FLOAT = 3'd3,
      MODE_OP    = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      EMIT_IDLE = 2'd0,
      EMIT_RUN  = 2'd1
   } emit_state_type;

   localparam logic [5:0] TYPE_IDENT = 6'd0;
   localparam logic [5:0] TYPE_INT   = 6'd1;
   localparam logic [5:0] TYPE_FLOAT = 6'd2;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a)) || (c == 8'h5f);
   endfunction

   function automatic logic is_opchar(input logic [7:0] c);
      return c == 8'h2b || c == 8'h2d || c == 8'h2a || c == 8'h2f || c == 8'h25 ||
             c == 8'h3c || c == 8'h3e || c == 8'h3d || c == 8'h21 || c == 8'h26 ||
             c == 8'h7c;
   endfunction

   function automatic logic is_sign(input logic [7:0] c);
      return is_opchar(c) || c == 8'h3a || c == 8'h3b || c == 8'h2c || c == 8'h28 ||
             c == 8'h29 || c == 8'h7b || c == 8'h7d || c == 8'h5b || c == 8'h5d;
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
             ((c >= 8'h41) && (c <= 8'h46)) || c == 8'h78;
   endfunction

   function automatic logic is_numchar(input logic [7:0] c);
      return is_digit(c) || c == 8'h2e || c == 8'h65 || c == 8'h45 ||
             c == 8'h2b || c == 8'h2d;
   endfunction

   // keyword and operator lookup on up to eight characters; 0 means no match
   function automatic logic [5:0] lookup(input logic [63:0] t, input logic [3:0] n);
      logic [5:0] r;
      r = 6'd0;
      case (n)
         4'd1: begin
            case (t[7:0])
               8'h2b: r = 6'd13;
               8'h2d: r = 6'd14;
               8'h2a: r = 6'd15;
               8'h2f: r = 6'd16;
               8'h25: r = 6'd17;
               8'h3c: r = 6'd18;
               8'h3e: r = 6'd19;
               8'h3d: r = 6'd20;
               8'h28: r = 6'd27;
               8'h29: r = 6'd28;
               8'h5b: r = 6'd29;
               8'h5d: r = 6'd30;
               8'h7b: r = 6'd31;
               8'h7d: r = 6'd32;
               8'h2c: r = 6'd33;
               8'h3b: r = 6'd34;
               8'h3a: r = 6'd35;
               8'h21: r = 6'd36;
               default: r = 6'd0;
            endcase
         end
         4'd2: begin
            case (t[15:0])
               16'h3d3c: r = 6'd21;
               16'h3d3e: r = 6'd22;
               16'h3d3d: r = 6'd23;
               16'h3d21: r = 6'd24;
               16'h2626: r = 6'd25;
               16'h7c7c: r = 6'd26;
               16'h6669: r = 6'd7;
               default: r = 6'd0;
            endcase
         end
         4'd3: r = (t[23:0] == 24'h746e69) ? 6'd5 : 6'd0;
         4'd4: begin
            case (t[31:0])
               32'h64696f76: r = 6'd4;
               32'h65736c65: r = 6'd8;
               default: r = 6'd0;
            endcase
         end
         4'd5: begin
            case (t[39:0])
               40'h74736e6f63: r = 6'd3;
               40'h74616f6c66: r = 6'd6;
               40'h656c696877: r = 6'd9;
               40'h6b61657262: r = 6'd11;
               default: r = 6'd0;
            endcase
         end
         4'd6: r = (t[47:0] == 48'h6e7275746572) ? 6'd12 : 6'd0;
         4'd8: r = (t == 64'h65756e69746e6f63) ? 6'd10 : 6'd0;
         default: r = 6'd0;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/ltd_ram.sv -----
// ltd_ram: generic single write port, single registered read port memory
// no dependencies
module ltd_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/ltd_front.sv -----
// ltd_front: character automaton, builds tokens and hands finished ones to the back end
// depends on ltd_pkg; text goes to one of two ltd_ram banks in the back end
module ltd_front import ltd_pkg::*; #(
   parameter int MaxLen = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [7:0]                  req_ch,
   // token descriptor queue
   output logic                        tq_push,
   input  logic                        tq_full,
   output logic [5:0]                  tq_type,
   output logic [$clog2(MaxLen+1)-1:0] tq_len,
   output logic                        tq_trunc,
   output logic                        tq_bank,
   // text write port
   output logic                        wr_en,
   output logic                        wr_bank,
   output logic [$clog2(MaxLen)-1:0]   wr_addr,
   output logic [7:0]                  wr_data,
   // bank still owned by the back end
   input  logic [1:0]                  bank_busy
);
   localparam int LW = $clog2(MaxLen+1);
   localparam int AW = $clog2(MaxLen);

   mode_type        mode_ff, mode_in;
   logic [LW-1:0]   len_ff, len_in;
   logic            dot_ff, dot_in, num_ff, num_in, ovf_ff, ovf_in;
   logic [7:0]      last_ff, last_in;
   logic            bank_ff, bank_in;
   logic [63:0]     head_ff, head_in;
   logic [7:0]      first_ff, first_in;

   logic [7:0] c;
   logic d, l, s, dot, acc;
   logic emit, start, push;

   assign c = req_ch;
   assign d = is_digit(c);
   assign l = is_letter(c);
   assign s = is_sign(c);
   assign dot = (c == 8'h2e);

   // a flush needs a free queue slot and the other text bank
   assign req_full = tq_full || bank_busy[~bank_ff];
   assign acc = req_push && !req_full;

   always_comb begin
      mode_in = mode_ff;
      emit = 1'b0;
      start = 1'b0;
      push = 1'b0;
      unique case (mode_ff)
         MODE_EMPTY: begin
            start = d || l || s || dot;
            if (d) mode_in = MODE_INT;
            else if (l) mode_in = MODE_IDENT;
            else if (s) mode_in = MODE_OP;
            else if (dot) mode_in = MODE_FLOAT;
         end
         MODE_IDENT: begin
            if (d || l) push = 1'b1;
            else if (!dot) emit = 1'b1;
         end
         MODE_INT: begin
            if (d || is_hex(c)) push = 1'b1;
            else if (dot) begin
               push = 1'b1;
               mode_in = MODE_FLOAT;
            end else emit = 1'b1;
         end
         MODE_FLOAT: begin
            if (d) push = 1'b1;
            else emit = 1'b1;
         end
         MODE_OP: begin
            if (((last_ff == 8'h3d || last_ff == 8'h7c || last_ff == 8'h26) && last_ff == c)
                || (is_opchar(last_ff) && c == 8'h3d)) push = 1'b1;
            else emit = 1'b1;
         end
         default: mode_in = MODE_EMPTY;
      endcase
      if (emit) begin
         if (s) mode_in = MODE_OP;
         else if (mode_ff == MODE_OP && d) mode_in = MODE_INT;
         else if (mode_ff == MODE_OP && l) mode_in = MODE_IDENT;
         else if (mode_ff == MODE_OP && dot) mode_in = MODE_FLOAT;
         else mode_in = MODE_EMPTY;
         start = (mode_in != MODE_EMPTY);
      end
   end

   // token type of the pending text
   logic [5:0] kw, ttype;
   assign kw = (len_ff <= LW'(8)) ? lookup(head_ff, 4'(len_ff)) : 6'd0;
   always_comb begin
      if (kw != 6'd0) ttype = kw;
      else if (is_digit(first_ff) || first_ff == 8'h2e)
         ttype = (dot_ff && num_ff) ? TYPE_FLOAT : TYPE_INT;
      else ttype = TYPE_IDENT;
   end

   logic [LW-1:0] base_len;
   logic          base_dot, base_num, base_ovf, room;
   logic [63:0]   base_head;
   always_comb begin
      base_len = start ? '0 : len_ff;
      base_dot = start ? 1'b0 : dot_ff;
      base_num = start ? 1'b1 : num_ff;
      base_ovf = start ? 1'b0 : ovf_ff;
      base_head = head_ff;
      room = base_len < LW'(MaxLen);
      len_in = len_ff; dot_in = dot_ff; num_in = num_ff; ovf_in = ovf_ff;
      last_in = last_ff; head_in = head_ff; first_in = first_ff;
      bank_in = emit ? ~bank_ff : bank_ff;
      if (acc) begin
         if (emit && !start) begin
            len_in = '0; dot_in = 1'b0; num_in = 1'b1; ovf_in = 1'b0; last_in = 8'd0;
         end
         if (start || push) begin
            last_in = c;
            len_in = base_len; dot_in = base_dot; num_in = base_num; ovf_in = base_ovf;
            if (room) begin
               len_in = base_len + LW'(1);
               if (dot || c == 8'h65 || c == 8'h45) dot_in = 1'b1;
               if (!is_numchar(c)) num_in = 1'b0;
               if (base_len < LW'(8)) begin
                  base_head[base_len[2:0]*8 +: 8] = c;
                  head_in = base_head;
               end
               if (base_len == '0) first_in = c;
            end else ovf_in = 1'b1;
         end
      end else bank_in = bank_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_EMPTY;
         len_ff <= '0;
         dot_ff <= 1'b0;
         num_ff <= 1'b1;
         ovf_ff <= 1'b0;
         last_ff <= 8'd0;
         bank_ff <= 1'b0;
      end else if (acc) begin
         mode_ff <= mode_in;
         len_ff <= len_in;
         dot_ff <= dot_in;
         num_ff <= num_in;
         ovf_ff <= ovf_in;
         last_ff <= last_in;
         bank_ff <= bank_in;
      end
      head_ff <= head_in;
      first_ff <= first_in;
   end

   assign tq_push = acc && emit && (len_ff != '0);
   assign tq_type = ttype;
   assign tq_len = len_ff;
   assign tq_trunc = ovf_ff;
   assign tq_bank = bank_ff;

   // stored text goes into the bank the token will own
   assign wr_en = acc && (start || push) && room;
   assign wr_bank = emit ? ~bank_ff : bank_ff;
   assign wr_addr = AW'(base_len);
   assign wr_data = c;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(MaxLen)) else $error("token length beyond buffer");
   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_EMPTY |-> len_ff == '0) else $error("empty mode holds text");
   a_flush_bank: assert property (@(posedge clock) disable iff (reset)
      tq_push |=> bank_ff != $past(bank_ff)) else $error("bank not flipped on flush");
endmodule

// ----- rtl/ltd_back.sv -----
// ltd_back: descriptor queue and replay of stored token text as a result stream
// depends on ltd_pkg and ltd_ram
module ltd_back import ltd_pkg::*; #(
   parameter int MaxLen = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        tq_push,
   output logic                        tq_full,
   input  logic [5:0]                  tq_type,
   input  logic [$clog2(MaxLen+1)-1:0] tq_len,
   input  logic                        tq_trunc,
   input  logic                        tq_bank,
   input  logic                        wr_en,
   input  logic                        wr_bank,
   input  logic [$clog2(MaxLen)-1:0]   wr_addr,
   input  logic [7:0]                  wr_data,
   output logic [1:0]                  bank_busy,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [5:0]                  rsp_token_type,
   output logic [7:0]                  rsp_token_char,
   output logic [4:0]                  rsp_char_pos,
   output logic [5:0]                  rsp_token_len,
   output logic                        rsp_truncated,
   output logic                        rsp_last
);
   localparam int LW = $clog2(MaxLen+1);
   localparam int AW = $clog2(MaxLen);

   // two-entry descriptor queue, entry i describes bank i
   logic [1:0]    qv_ff, qv_in;
   logic [5:0]    qtype_ff [2];
   logic [LW-1:0] qlen_ff [2];
   logic          qtr_ff [2];
   logic          rd_bank_ff;

   assign tq_full = qv_ff[0] && qv_ff[1];
   assign bank_busy = qv_ff;

   // replay state
   emit_state_type st_ff, st_in;
   logic [LW-1:0]  rpos_ff, rpos_in;   // next address to read
   logic           ov_ff;              // output register holds a result
   logic [LW-1:0]  opos_ff;
   logic           olast_ff;
   logic           rd_fire, rd_fire_ff, take;
   logic [7:0]     rd0, rd1;

   ltd_ram #(.Width(8), .Depth(MaxLen)) u_ram0 (
      .clock(clock), .wr_en(wr_en && !wr_bank), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(AW'(rpos_ff)), .rd_data(rd0));
   ltd_ram #(.Width(8), .Depth(MaxLen)) u_ram1 (
      .clock(clock), .wr_en(wr_en && wr_bank), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(AW'(rpos_ff)), .rd_data(rd1));

   logic [LW-1:0] cur_len;
   assign cur_len = qlen_ff[rd_bank_ff];
   assign take = rsp_pop && ov_ff;

   // one read in flight at a time; the output register is the only holding place
   assign rd_fire = (st_ff == EMIT_RUN) && !rd_fire_ff && (!ov_ff || take);

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         // the previous run must have fully left the output register
         EMIT_IDLE: if (qv_ff[rd_bank_ff] && !ov_ff && !rd_fire_ff) st_in = EMIT_RUN;
         EMIT_RUN: if (rd_fire && rpos_ff + LW'(1) == cur_len) st_in = EMIT_IDLE;
         default: st_in = EMIT_IDLE;
      endcase
      rpos_in = rpos_ff;
      if (st_ff == EMIT_IDLE) rpos_in = '0;
      else if (rd_fire) rpos_in = rpos_ff + LW'(1);
   end

   logic [7:0] ochar_ff;
   logic       done_bank;
   assign done_bank = take && olast_ff;

   always_comb begin
      qv_in = qv_ff;
      if (tq_push) qv_in[tq_bank] = 1'b1;
      if (done_bank) qv_in[rd_bank_ff] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qv_ff <= 2'b00;
         rd_bank_ff <= 1'b0;
         st_ff <= EMIT_IDLE;
         rpos_ff <= '0;
         rd_fire_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         rpos_ff <= rpos_in;
         rd_fire_ff <= rd_fire;
         qv_ff <= qv_in;
         if (done_bank) rd_bank_ff <= ~rd_bank_ff;
         if (rd_fire_ff) ov_ff <= 1'b1;
         else if (take) ov_ff <= 1'b0;
      end
      if (tq_push) begin
         qtype_ff[tq_bank] <= tq_type;
         qlen_ff[tq_bank] <= tq_len;
         qtr_ff[tq_bank] <= tq_trunc;
      end
      if (rd_fire) begin
         opos_ff <= rpos_ff;
         olast_ff <= (rpos_ff + LW'(1) == cur_len);
      end
      if (rd_fire_ff) ochar_ff <= rd_bank_ff ? rd1 : rd0;
   end

   assign rsp_empty = !ov_ff;
   assign rsp_token_type = qtype_ff[rd_bank_ff];
   assign rsp_token_char = ochar_ff;
   assign rsp_char_pos = 5'(opos_ff);
   assign rsp_token_len = 6'(cur_len);
   assign rsp_truncated = qtr_ff[rd_bank_ff];
   assign rsp_last = olast_ff;

   a_run_valid: assert property (@(posedge clock) disable iff (reset)
      ov_ff |-> qv_ff[rd_bank_ff]) else $error("result without descriptor");
   a_one_read: assert property (@(posedge clock) disable iff (reset)
      rd_fire |=> !rd_fire) else $error("two reads in flight");
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      tq_push |-> !qv_ff[tq_bank]) else $error("push into busy bank");
endmodule

// ----- rtl/lexer_token_dfa_core.sv -----
// Lexer token automaton. One source byte is taken per cycle while a token
// builds and req_full is low; when a token ends, its stored characters are
// replayed one result at a time from a text bank (registered RAM read then
// output register), with no new read issued while one is still in flight.
// The byte that ends a token may start the next one in the other bank, and
// further input is held off until the ended token has fully drained; the
// drain stalls while pop is low.
// depends on ltd_pkg, ltd_front and ltd_back
module lexer_token_dfa_core import ltd_pkg::*; #(
   parameter int MAX_TOKEN_LEN = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_ch,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [5:0] rsp_token_type,
   output logic [7:0] rsp_token_char,
   output logic [4:0] rsp_char_pos,
   output logic [5:0] rsp_token_len,
   output logic       rsp_truncated,
   output logic       rsp_last
);
   localparam int LW = $clog2(MAX_TOKEN_LEN+1);
   localparam int AW = $clog2(MAX_TOKEN_LEN);

   logic          tq_push, tq_full, tq_trunc, tq_bank;
   logic [5:0]    tq_type;
   logic [LW-1:0] tq_len;
   logic          wr_en, wr_bank;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic [1:0]    bank_busy;

   ltd_front #(.MaxLen(MAX_TOKEN_LEN)) u_front (
      .clock, .reset, .req_push, .req_full, .req_ch,
      .tq_push, .tq_full, .tq_type, .tq_len, .tq_trunc, .tq_bank,
      .wr_en, .wr_bank, .wr_addr, .wr_data, .bank_busy);

   ltd_back #(.MaxLen(MAX_TOKEN_LEN)) u_back (
      .clock, .reset, .tq_push, .tq_full, .tq_type, .tq_len, .tq_trunc, .tq_bank,
      .wr_en, .wr_bank, .wr_addr, .wr_data, .bank_busy,
      .rsp_empty, .rsp_pop, .rsp_token_type, .rsp_token_char, .rsp_char_pos,
      .rsp_token_len, .rsp_truncated, .rsp_last);
endmodule

// ----- dv/lexer_scoreboard.sv -----
// lexer_scoreboard: token predictor and expected-result store for the lexer core
// depends on ltd_pkg for the automaton mode enum and token type constants
`timescale 1ns / 1ps

class lexer_scoreboard;
   typedef struct packed {
      logic [5:0] token_type;
      logic [7:0] token_char;
      logic [4:0] char_pos;
      logic [5:0] token_len;
      logic       truncated;
      logic       last;
   } lex_result_type;

   localparam int TOKEN_MAX = 32;

   ltd_pkg::mode_type mode;
   logic [7:0]  text [TOKEN_MAX];
   int          text_len;
   bit          has_dot_exp;
   bit          numeric_only;
   bit          dropped;
   logic [7:0]  prev_ch;

   lex_result_type pending_chars[$];
   int          mismatch_count;
   int          checked_count;
   int          token_count;

   function new();
      mode = ltd_pkg::MODE_EMPTY;
      wipe();
      mismatch_count = 0;
      checked_count = 0;
      token_count = 0;
   endfunction

   static function bit digit_c(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction
   static function bit letter_c(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
   endfunction
   static function bit opchar_c(logic [7:0] c);
      return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" || c == "<" ||
             c == ">" || c == "=" || c == "!" || c == "&" || c == "|";
   endfunction
   static function bit sign_c(logic [7:0] c);
      return opchar_c(c) || c == ":" || c == ";" || c == "," || c == "(" || c == ")" ||
             c == "{" || c == "}" || c == "[" || c == "]";
   endfunction
   static function bit hex_c(logic [7:0] c);
      return digit_c(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F") || c == "x";
   endfunction

   function void wipe();
      text_len = 0;
      has_dot_exp = 0;
      numeric_only = 1;
      dropped = 0;
      prev_ch = 8'd0;
   endfunction

   function void append(logic [7:0] c);
      prev_ch = c;
      if (text_len < TOKEN_MAX) begin
         text[text_len] = c;
         text_len++;
         if (c == "." || c == "e" || c == "E") has_dot_exp = 1;
         if (!(digit_c(c) || c == "." || c == "e" || c == "E" || c == "+" || c == "-"))
            numeric_only = 0;
      end else begin
         dropped = 1;
      end
   endfunction

   function void begin_token(logic [7:0] c, ltd_pkg::mode_type m);
      wipe();
      append(c);
      mode = m;
   endfunction

   function logic [5:0] token_kind();
      string words[34] = '{"const", "void", "int", "float", "if", "else", "while",
         "continue", "break", "return", "+", "-", "*", "/", "%", "<", ">", "=",
         "<=", ">=", "==", "!=", "&&", "||", "(", ")", "[", "]", "{", "}", ",",
         ";", ":", "!"};
      string s;
      s = "";
      for (int i = 0; i < text_len; i++) s = {s, string'(text[i])};
      for (int k = 0; k < 34; k++)
         if (words[k] == s && words[k].len() == text_len) return 6'(k + 3);
      if (text_len > 0 && (digit_c(text[0]) || text[0] == "."))
         return (has_dot_exp && numeric_only) ? ltd_pkg::TYPE_FLOAT : ltd_pkg::TYPE_INT;
      return ltd_pkg::TYPE_IDENT;
   endfunction

   function void flush_token();
      lex_result_type r;
      logic [5:0] kind;
      kind = token_kind();
      if (text_len > 0) token_count++;
      for (int i = 0; i < text_len; i++) begin
         r.token_type = kind;
         r.token_char = text[i];
         r.char_pos   = 5'(i);
         r.token_len  = 6'(text_len);
         r.truncated  = dropped;
         r.last       = (i + 1 == text_len);
         pending_chars.insert(pending_chars.size(), r);
      end
   endfunction

   // advance the automaton by one accepted request
   function void note_char(logic [7:0] c);
      bit d, l, s, dot;
      d = digit_c(c); l = letter_c(c); s = sign_c(c); dot = (c == ".");
      case (mode)
         ltd_pkg::MODE_EMPTY: begin
            if (d) begin_token(c, ltd_pkg::MODE_INT);
            else if (l) begin_token(c, ltd_pkg::MODE_IDENT);
            else if (s) begin_token(c, ltd_pkg::MODE_OP);
            else if (dot) begin_token(c, ltd_pkg::MODE_FLOAT);
            return;
         end
         ltd_pkg::MODE_IDENT: begin
            if (d || l) begin append(c); return; end
            if (dot) return;
         end
         ltd_pkg::MODE_INT: begin
            if (hex_c(c)) begin append(c); return; end
            if (dot) begin append(c); mode = ltd_pkg::MODE_FLOAT; return; end
         end
         ltd_pkg::MODE_FLOAT: begin
            if (d) begin append(c); return; end
         end
         ltd_pkg::MODE_OP: begin
            if ((prev_ch == "=" || prev_ch == "|" || prev_ch == "&") && prev_ch == c) begin
               append(c);
               return;
            end
            if (opchar_c(prev_ch) && c == "=") begin append(c); return; end
            flush_token();
            if (s) begin_token(c, ltd_pkg::MODE_OP);
            else if (d) begin_token(c, ltd_pkg::MODE_INT);
            else if (l) begin_token(c, ltd_pkg::MODE_IDENT);
            else if (dot) begin_token(c, ltd_pkg::MODE_FLOAT);
            else begin wipe(); mode = ltd_pkg::MODE_EMPTY; end
            return;
         end
         default: begin
            wipe();
            mode = ltd_pkg::MODE_EMPTY;
            return;
         end
      endcase
      // identifier, integer or float ends
      flush_token();
      if (s) begin_token(c, ltd_pkg::MODE_OP);
      else begin wipe(); mode = ltd_pkg::MODE_EMPTY; end
   endfunction

   function void check_char(lex_result_type got);
      lex_result_type want;
      checked_count++;
      if (pending_chars.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected result: type %0d char %h pos %0d len %0d trunc %0d last %0d",
                     got.token_type, got.token_char, got.char_pos, got.token_len,
                     got.truncated, got.last);
         return;
      end
      want = pending_chars.pop_front();
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("mismatch: expected type %0d char %h pos %0d len %0d trunc %0d last %0d",
                     want.token_type, want.token_char, want.char_pos, want.token_len,
                     want.truncated, want.last);
            $display("          got      type %0d char %h pos %0d len %0d trunc %0d last %0d",
                     got.token_type, got.token_char, got.char_pos, got.token_len,
                     got.truncated, got.last);
         end
      end
   endfunction
endclass

// ----- dv/tb_top.sv -----
// tb_top: drives lexer_token_dfa_core with directed and random source text
// depends on ltd_pkg, lexer_scoreboard and the core rtl
`timescale 1ns / 1ps

module tb_top;
   import ltd_pkg::*;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_ch = 8'd0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [5:0] rsp_token_type;
   logic [7:0] rsp_token_char;
   logic [4:0] rsp_char_pos;
   logic [5:0] rsp_token_len;
   logic       rsp_truncated;
   logic       rsp_last;

   lexer_scoreboard lex_sb = new();
   int  send_idle_pct = 6;
   int  recv_idle_pct = 59;
   bit  hold_off = 0;
   int  cycle_count = 0;
   logic [7:0] src_text[$];

   lexer_token_dfa_core u_top (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side: randomly stalled pop, check on popped results
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         lex_sb.check_char({rsp_token_type, rsp_token_char, rsp_char_pos, rsp_token_len,
                            rsp_truncated, rsp_last});
      rsp_pop <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_ch   <= c;
      do @(posedge clock); while (req_full);
      lex_sb.note_char(c);
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_char(s[i]);
   endtask

   function automatic logic [7:0] pick(input string set);
      return set[$urandom_range(set.len() - 1)];
   endfunction

   // one random lexeme, mostly well formed
   task automatic send_random_lexeme();
      int n;
      case ($urandom_range(9))
         0, 1: begin
            send_char(pick("abcxyzEe_QZ"));
            n = $urandom_range(6);
            repeat (n) send_char(pick("abz_09Ze."));
         end
         2, 3: begin
            n = $urandom_range(1, 5);
            repeat (n) send_char(pick("0123456789abfxAF"));
            if ($urandom_range(1)) begin
               send_char(".");
               repeat ($urandom_range(3)) send_char(pick("0123456789"));
            end
         end
         4, 5: begin
            send_char(pick("+-*/%<>=!&|:;,(){}[]"));
            if ($urandom_range(1)) send_char(pick("=&|"));
         end
         6: send_text("return");
         7: send_char(8'($urandom_range(255)));
         8: repeat ($urandom_range(2, 4)) send_char(pick("ab_9"));
         default: send_char(pick(" \t\n"));
      endcase
      if ($urandom_range(2) == 0) send_char(" ");
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (lex_sb.pending_chars.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: keywords, operators, merges, numbers, truncation, high bytes
      send_text("int if x<=y&&z||w&v===u ");
      send_text("0x1F 1.e a.b 9z .5 ");
      send_char(8'hff);
      send_text("abcdefghijklmnopqrstuvwxyz0123456 ");
      send_char(8'h00);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 59 : 0;
         recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 6 : 0;
         if (phase == 0) fork
            begin
               hold_off = 1;
               repeat (600) @(posedge clock);
               hold_off = 0;
            end
         join_none
         repeat (3) send_random_lexeme();
         send_char(8'h00);
      end
      req_push <= 1'b0;
      drain();

      $display("checked %0d result chars over %0d tokens, three idling phases and a long stall",
               lex_sb.checked_count, lex_sb.token_count);
      if (lex_sb.mismatch_count == 0 && lex_sb.pending_chars.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule

// ----- filelist.f -----
rtl/ltd_pkg.sv
rtl/ltd_ram.sv
rtl/ltd_front.sv
rtl/ltd_back.sv
rtl/lexer_token_dfa_core.sv
dv/lexer_scoreboard.sv
dv/tb_top.sv
